// File: rtl/nni_pkg.sv
// Shared types and constants for the nearest-neighbor image scaler.
package nni_pkg;

  localparam int W_W   = 13;
  localparam int PCT_W = 10;
  localparam int OW_W  = 16;
  localparam int TOT_W = 26;
  localparam int Q_W   = 13;
  localparam int QS_W  = 7;
  localparam int X_W   = 23;
  localparam int RCP_W = 26;
  localparam int RCP_SH = 32;
  localparam logic [RCP_W-1:0] RECIP_100 = RCP_W'(42949673);
  localparam logic [6:0] STEP_DIVIDEND = 7'd100;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP        = 2'd2;
  localparam logic [1:0] REG_SCALE      = 2'd3;

  typedef struct packed {
    logic [W_W-1:0]   w;
    logic [W_W-1:0]   h;
    logic [PCT_W-1:0] pct;
    logic [31:0]      mask;
    logic [TOT_W-1:0] total;
    logic [OW_W-1:0]  ow;
    logic [OW_W-1:0]  oh;
    logic [QS_W-1:0]  q0;
    logic [PCT_W-1:0] r0;
  } nni_cfg_t;

  typedef struct packed {
    logic        is_emit;
    logic [31:0] pixel;
  } nni_req_t;

endpackage

// File: rtl/nni_cfg.sv
// Configuration registers, clamping and derived frame geometry.
module nni_cfg import nni_pkg::*; #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_SCALE_PERCENT = 400
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  logic [1:0] index,
  input  logic [9:0] data,
  output nni_cfg_t   cfg,
  output logic       settling
);
  localparam logic [3:0] SETTLE = 4'd10;

  logic [9:0] raw_w, raw_h;
  logic [2:0] raw_bpp;
  logic [8:0] raw_pct;
  logic [3:0] cnt;
  logic [X_W-1:0] wx, hx;
  logic [X_W+RCP_W-1:0] wp, hp;
  logic [PCT_W:0] drem;
  logic [6:0] dquo;
  logic [PCT_W:0] dtry;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_w <= 10'd512;
      raw_h <= 10'd512;
      raw_bpp <= 3'd3;
      raw_pct <= 9'd100;
      cnt <= SETTLE;
    end else begin
      if (wr) begin
        cnt <= SETTLE;
        case (index)
          REG_SRC_WIDTH:  raw_w <= data;
          REG_SRC_HEIGHT: raw_h <= data;
          REG_BPP:        raw_bpp <= data[2:0];
          REG_SCALE:      raw_pct <= data[8:0];
          default: ;
        endcase
      end else if (cnt != 4'd0) begin
        cnt <= cnt - 4'd1;
      end
    end
  end

  assign settling = (cnt != 4'd0);
  assign dtry = {drem[PCT_W-1:0], dquo[6]};

  always_ff @(posedge clk) begin
    cfg.w <= (raw_w == 10'd0) ? W_W'(1) :
             (W_W'(raw_w) > W_W'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(raw_w);
    cfg.h <= (raw_h == 10'd0) ? W_W'(1) :
             (W_W'(raw_h) > W_W'(MAX_HEIGHT)) ? W_W'(MAX_HEIGHT) : W_W'(raw_h);
    cfg.pct <= (raw_pct == 9'd0) ? PCT_W'(1) :
               (PCT_W'(raw_pct) > PCT_W'(MAX_SCALE_PERCENT)) ?
               PCT_W'(MAX_SCALE_PERCENT) : PCT_W'(raw_pct);
    case (raw_bpp)
      3'd0, 3'd1: cfg.mask <= 32'h0000_00FF;
      3'd2:       cfg.mask <= 32'h0000_FFFF;
      3'd3:       cfg.mask <= 32'h00FF_FFFF;
      default:    cfg.mask <= 32'hFFFF_FFFF;
    endcase
    cfg.total <= TOT_W'(cfg.w) * TOT_W'(cfg.h);
    wx <= X_W'(cfg.w) * X_W'(cfg.pct) + X_W'(50);
    hx <= X_W'(cfg.h) * X_W'(cfg.pct) + X_W'(50);
    wp <= wx * RECIP_100;
    hp <= hx * RECIP_100;
    cfg.ow <= wp[RCP_SH +: OW_W];
    cfg.oh <= hp[RCP_SH +: OW_W];
    // restoring divide of 100 by the scale, one bit a cycle
    if (cnt == SETTLE - 4'd1) begin
      drem <= '0;
      dquo <= STEP_DIVIDEND;
    end else if (cnt != 4'd0) begin
      if (dtry >= {1'b0, cfg.pct}) begin
        drem <= dtry - {1'b0, cfg.pct};
        dquo <= {dquo[5:0], 1'b1};
      end else begin
        drem <= dtry;
        dquo <= {dquo[5:0], 1'b0};
      end
    end
    if (cnt == 4'd1) begin
      cfg.q0 <= dquo;
      cfg.r0 <= drem[PCT_W-1:0];
    end
  end
endmodule

// File: rtl/nni_front.sv
// Request intake, classification and a two-entry request queue.
module nni_front import nni_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        req_type,
  input  logic [31:0] pixel_in,
  input  logic        hold,
  input  nni_cfg_t    cfg,
  output logic        busy,
  output logic        q_valid,
  output nni_req_t    q_head
);
  nni_req_t   slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push, pop;

  assign busy = hold || (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid;
  assign q_head = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].is_emit <= req_type;
      slot[wr_ptr].pixel <= req_type ? 32'd0 : (pixel_in & cfg.mask);
    end
    if (rst) begin
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/nni_back.sv
// Request execution: output walk, source stepping and frame store.
module nni_back import nni_pkg::*; #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  nni_req_t    q_head,
  input  nni_cfg_t    cfg,
  output logic        out_valid,
  output logic [31:0] pixel_out,
  output logic [10:0] out_col,
  output logic [10:0] out_row,
  output logic        last_in_row,
  output logic        last_of_image
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] store [DEPTH];

  logic [AW-1:0]    load_pos;
  logic [OW_W-1:0]  ecol, erow;
  logic [Q_W-1:0]   qcol, qrow;
  logic [PCT_W-1:0] rcol, rrow;

  logic [AW-1:0]    pos;
  logic             restart, empty, lr, li;
  logic [OW_W-1:0]  col, row;
  logic [Q_W-1:0]   qc, qr, qc_n, qr_n;
  logic [PCT_W-1:0] rc, rr, rc_n, rr_n;
  logic [PCT_W:0]   rc_s, rr_s;

  logic             s1_v, s1_load, s1_inr, s1_lr, s1_li;
  logic [AW-1:0]    s1_pos;
  logic [Q_W-1:0]   s1_qc, s1_qr;
  logic [31:0]      s1_pix;
  logic [10:0]      s1_col, s1_row;

  logic             s2_v, s2_load, s2_inr, s2_lr, s2_li;
  logic [AW-1:0]    s2_addr;
  logic [31:0]      s2_pix;
  logic [10:0]      s2_col, s2_row;

  logic             s3_v, s3_inr;
  logic [31:0]      rd_data;

  always_comb begin
    pos = (TOT_W'(load_pos) >= cfg.total) ? '0 : load_pos;
    empty = (cfg.ow == '0) || (cfg.oh == '0);
    restart = (ecol >= cfg.ow) || (erow >= cfg.oh);
    col = restart ? '0 : ecol;
    row = restart ? '0 : erow;
    qc = restart ? '0 : qcol;
    rc = restart ? '0 : rcol;
    qr = restart ? '0 : qrow;
    rr = restart ? '0 : rrow;
    lr = (col + OW_W'(1) == cfg.ow);
    li = lr && (row + OW_W'(1) == cfg.oh);
    rc_s = {1'b0, rc} + {1'b0, cfg.r0};
    if (rc_s >= {1'b0, cfg.pct}) begin
      rc_n = PCT_W'(rc_s - {1'b0, cfg.pct});
      qc_n = qc + Q_W'(cfg.q0) + Q_W'(1);
    end else begin
      rc_n = rc_s[PCT_W-1:0];
      qc_n = qc + Q_W'(cfg.q0);
    end
    rr_s = {1'b0, rr} + {1'b0, cfg.r0};
    if (rr_s >= {1'b0, cfg.pct}) begin
      rr_n = PCT_W'(rr_s - {1'b0, cfg.pct});
      qr_n = qr + Q_W'(cfg.q0) + Q_W'(1);
    end else begin
      rr_n = rr_s[PCT_W-1:0];
      qr_n = qr + Q_W'(cfg.q0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      ecol <= '0; erow <= '0;
      qcol <= '0; qrow <= '0;
      rcol <= '0; rrow <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= q_valid && (!q_head.is_emit || !empty);
      s2_v <= s1_v;
      s3_v <= s2_v && !s2_load;
      if (q_valid && !q_head.is_emit) begin
        load_pos <= (TOT_W'(pos) + TOT_W'(1) >= cfg.total) ? '0 : pos + AW'(1);
        if (pos == '0) begin
          ecol <= '0; erow <= '0;
          qcol <= '0; qrow <= '0;
          rcol <= '0; rrow <= '0;
        end
      end else if (q_valid && !empty) begin
        if (li) begin
          ecol <= '0; erow <= '0;
          qcol <= '0; qrow <= '0;
          rcol <= '0; rrow <= '0;
        end else if (lr) begin
          ecol <= '0; qcol <= '0; rcol <= '0;
          erow <= row + OW_W'(1); qrow <= qr_n; rrow <= rr_n;
        end else begin
          ecol <= col + OW_W'(1); qcol <= qc_n; rcol <= rc_n;
          erow <= row; qrow <= qr; rrow <= rr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_load <= !q_head.is_emit;
    s1_pos <= pos;
    s1_pix <= q_head.pixel;
    s1_qc <= qc;
    s1_qr <= qr;
    s1_inr <= (qc < cfg.w) && (qr < cfg.h);
    s1_col <= col[10:0];
    s1_row <= row[10:0];
    s1_lr <= lr;
    s1_li <= li;

    s2_load <= s1_load;
    s2_addr <= s1_load ? s1_pos : AW'(s1_qr * cfg.w + TOT_W'(s1_qc));
    s2_pix <= s1_pix;
    s2_inr <= s1_inr;
    s2_col <= s1_col;
    s2_row <= s1_row;
    s2_lr <= s1_lr;
    s2_li <= s1_li;

    s3_inr <= s2_inr;
    out_col <= s2_col;
    out_row <= s2_row;
    last_in_row <= s2_lr;
    last_of_image <= s2_li;
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      if (s2_load) store[s2_addr] <= s2_pix;
      else rd_data <= store[s2_addr];
    end
  end

  assign out_valid = s3_v;
  assign pixel_out = s3_inr ? rd_data : 32'd0;
endmodule

// File: rtl/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler.
// Usage:
//   Requests enter on start/req_type/pixel_in and are taken at an edge with
//   start high and busy low. A load request (req_type 0) writes the next
//   source pixel in raster order; a load to position zero restarts the
//   output walk. An emit request (req_type 1) yields the next output pixel.
//   Configuration is written on cfg_valid/cfg_ready/cfg_index/cfg_data
//   by the user only while the block is idle (not enforced); cfg_ready is always high.
// Timing:
//   One request per cycle is sustained while busy is low. An emit result
//   passes the request queue and stages s1 and s2 and appears on out_valid
//   from stage s3, held for one cycle. The output walk stepper advances
//   once per emit request. After reset and after every configuration write,
//   busy stays high while the geometry and the 100/scale step are
//   recomputed by a bit-serial divider.
// Reset: synchronous, clears queue, walk and load position; registers take
//   512x512, 3 bytes per pixel, 100 percent. Frame store is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module nearest_neighbor_image_scaler import nni_pkg::*; #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_SCALE_PERCENT = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] pixel_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output logic        out_valid,
  output logic [31:0] pixel_out,
  output logic [10:0] out_col,
  output logic [10:0] out_row,
  output logic        last_in_row,
  output logic        last_of_image
);
  nni_cfg_t cfg;
  nni_req_t q_head;
  logic     settling, q_valid;

  assign cfg_ready = 1'b1;

  nni_cfg #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE_PERCENT(MAX_SCALE_PERCENT)
  ) u_cfg (
    .clk(clk), .rst(rst),
    .wr(cfg_valid && cfg_ready), .index(cfg_index), .data(cfg_data),
    .cfg(cfg), .settling(settling)
  );

  nni_front u_front (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .pixel_in(pixel_in), .hold(settling), .cfg(cfg), .busy(busy),
    .q_valid(q_valid), .q_head(q_head)
  );

  nni_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .cfg(cfg),
    .out_valid(out_valid), .pixel_out(pixel_out), .out_col(out_col),
    .out_row(out_row), .last_in_row(last_in_row), .last_of_image(last_of_image)
  );
endmodule
